[rtl/qpud_pkg.sv]
// Package for the query parameter URL decoder.
// Holds the phase and status codes, character constants and the hex helper.
// No dependencies.
package qpud_pkg;

  localparam int KEY_MAX_CHARS_DEF = 8;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_DATA_W-1:0] KEY_TEXT_RESET = 64'h6C6F_6361_7469_6F6E;  // "location"
  localparam logic [3:0] KEY_LENGTH_RESET = 4'd8;

  // Configuration register indexes.
  localparam logic REG_KEY_TEXT   = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [3:0] NAME_POS_MAX = 4'd15;

  typedef enum logic [1:0] {
    PH_NAME    = 2'd0,
    PH_VALUE   = 2'd1,
    PH_SKIP    = 2'd2,
    PH_SETTLED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_BAD_ESCAPE = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nibble = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nibble = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nibble = 4'(c - 8'h37);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

[rtl/qpud_stream_if.sv]
// Stream interfaces for the query parameter URL decoder.
// One interface for raw query bytes, one for decoded results; no dependencies.
interface qpud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, in_byte, last, input ready);
  modport sink   (input valid, in_byte, last, output ready);
endinterface

interface qpud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, out_byte, out_valid, done_res, status, input ready);
  modport sink   (input valid, out_byte, out_valid, done_res, status, output ready);
endinterface

[rtl/query_parameter_url_decoder.sv]
// Top level of the query parameter URL decoder.
// Depends on qpud_pkg and the stream interfaces in qpud_stream_if.sv.
//
//   channel  direction  handshake      payload
//   in_ch    sink       valid/ready    in_byte[7:0], last
//   out_ch   source     valid/ready    out_byte[7:0], out_valid, done_res, status[1:0]
//   cfg      write      cfg_wr_en      cfg_index, cfg_data[63:0]
//
// The parse state and the result register are updated at the edge that accepts a
// byte, and the result appears the cycle after.
// One byte per clock is sustained; the single result register is the only buffer,
// so a stalled output holds off the input only while that register is full.
// Reset (rst_n low, synchronous) clears parse state and result valid; restores key.
module query_parameter_url_decoder #(
  parameter int KEY_MAX_CHARS = qpud_pkg::KEY_MAX_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  qpud_in_if.sink                         in_ch,
  qpud_out_if.source                      out_ch,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [qpud_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qpud_pkg::*;

  localparam logic [3:0] KEY_MAX_W = 4'(KEY_MAX_CHARS);

  // Configuration.
  logic [7:0] key_chars_r [KEY_MAX_CHARS];
  logic [3:0] key_length_r;

  // Parse state.
  phase_t     phase_r, phase_nxt;
  logic [3:0] name_pos_r, name_pos_nxt;
  logic       name_mismatch_r, name_mismatch_nxt;
  esc_t       esc_r, esc_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic       value_seen_r, value_seen_nxt;
  status_t    final_status_r, final_status_nxt;

  // Result register.
  logic       res_vld_r;
  logic [7:0] res_byte_r, res_byte_nxt;
  logic       res_ov_r, res_ov_nxt;
  logic       res_done_r, res_done_nxt;
  status_t    res_status_r, res_status_nxt;

  logic       accept;
  logic [3:0] klen;
  logic [7:0] key_ch;
  logic [7:0] b;
  hex_t       hex;

  assign in_ch.ready = !res_vld_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = res_vld_r;
  assign out_ch.out_byte  = res_byte_r;
  assign out_ch.out_valid = res_ov_r;
  assign out_ch.done_res  = res_done_r;
  assign out_ch.status    = res_status_r;

  assign klen = (key_length_r > KEY_MAX_W) ? KEY_MAX_W : key_length_r;
  assign b    = in_ch.in_byte;
  assign hex  = hex_digit(b);

  always_comb begin
    key_ch = 8'd0;
    for (int i = 0; i < KEY_MAX_CHARS; i++) begin
      if (name_pos_r == 4'(i)) begin
        key_ch = key_chars_r[i];
      end
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    name_pos_nxt      = name_pos_r;
    name_mismatch_nxt = name_mismatch_r;
    esc_nxt           = esc_r;
    high_nibble_nxt   = high_nibble_r;
    value_seen_nxt    = value_seen_r;
    final_status_nxt  = final_status_r;
    res_byte_nxt      = 8'd0;
    res_ov_nxt        = 1'b0;
    res_done_nxt      = 1'b0;
    res_status_nxt    = ST_OK;

    case (phase_r)
      PH_NAME: begin
        if (b == CH_AMP) begin
          name_pos_nxt      = 4'd0;
          name_mismatch_nxt = 1'b0;
        end else if (b == CH_EQUAL) begin
          if (!name_mismatch_r && name_pos_r == klen) begin
            phase_nxt      = PH_VALUE;
            esc_nxt        = ESC_NONE;
            value_seen_nxt = 1'b0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else begin
          if (name_pos_r >= klen || b != key_ch) begin
            name_mismatch_nxt = 1'b1;
          end
          if (name_pos_r != NAME_POS_MAX) begin
            name_pos_nxt = name_pos_r + 4'd1;
          end
        end
      end
      PH_SKIP: begin
        if (b == CH_AMP) begin
          phase_nxt         = PH_NAME;
          name_pos_nxt      = 4'd0;
          name_mismatch_nxt = 1'b0;
        end
      end
      PH_VALUE: begin
        if (esc_r == ESC_NONE) begin
          if (b == CH_AMP) begin
            // No escape is pending here, so only an empty value can fail.
            final_status_nxt = value_seen_r ? ST_OK : ST_EMPTY;
            phase_nxt        = PH_SETTLED;
          end else if (b == CH_PLUS) begin
            res_byte_nxt = CH_SPACE;
            res_ov_nxt   = 1'b1;
          end else if (b == CH_PERCENT) begin
            esc_nxt = ESC_HIGH;
          end else begin
            res_byte_nxt = b;
            res_ov_nxt   = 1'b1;
          end
        end else if (!hex.is_hex) begin
          final_status_nxt = ST_BAD_ESCAPE;
          esc_nxt          = ESC_NONE;
          phase_nxt        = PH_SETTLED;
        end else if (esc_r == ESC_HIGH) begin
          high_nibble_nxt = hex.nibble;
          esc_nxt         = ESC_LOW;
        end else begin
          res_byte_nxt = {high_nibble_r, hex.nibble};
          res_ov_nxt   = 1'b1;
          esc_nxt      = ESC_NONE;
        end
        if (res_ov_nxt) begin
          value_seen_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (in_ch.last) begin
      // A value still open at the end of the string is closed here.
      if (phase_nxt == PH_VALUE) begin
        if (esc_nxt != ESC_NONE) begin
          final_status_nxt = ST_BAD_ESCAPE;
        end else if (!value_seen_nxt) begin
          final_status_nxt = ST_EMPTY;
        end else begin
          final_status_nxt = ST_OK;
        end
      end
      res_done_nxt      = 1'b1;
      res_status_nxt    = final_status_nxt;
      phase_nxt         = PH_NAME;
      name_pos_nxt      = 4'd0;
      name_mismatch_nxt = 1'b0;
      esc_nxt           = ESC_NONE;
      high_nibble_nxt   = 4'd0;
      value_seen_nxt    = 1'b0;
      final_status_nxt  = ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_MAX_CHARS; i++) begin
        key_chars_r[i] <= KEY_TEXT_RESET[CFG_DATA_W-1-8*i -: 8];
      end
      key_length_r <= KEY_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEY_TEXT: begin
          for (int i = 0; i < KEY_MAX_CHARS; i++) begin
            key_chars_r[i] <= cfg_data[CFG_DATA_W-1-8*i -: 8];
          end
        end
        REG_KEY_LENGTH: begin
          key_length_r <= cfg_data[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_NAME;
      name_pos_r      <= 4'd0;
      name_mismatch_r <= 1'b0;
      esc_r           <= ESC_NONE;
      high_nibble_r   <= 4'd0;
      value_seen_r    <= 1'b0;
      final_status_r  <= ST_NOT_FOUND;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      name_pos_r      <= name_pos_nxt;
      name_mismatch_r <= name_mismatch_nxt;
      esc_r           <= esc_nxt;
      high_nibble_r   <= high_nibble_nxt;
      value_seen_r    <= value_seen_nxt;
      final_status_r  <= final_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (accept) begin
      res_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_byte_r   <= res_byte_nxt;
      res_ov_r     <= res_ov_nxt;
      res_done_r   <= res_done_nxt;
      res_status_r <= res_status_nxt;
    end
  end

endmodule
